FILE: src/atc_pkg.sv
// shared types, constants and helpers for the atc texture block decoder
`default_nettype none

package atc_pkg;

	// stream payload widths
	localparam int unsigned BlockWidth  = 64;
	localparam int unsigned InDataWidth = 2 * BlockWidth;
	localparam int unsigned IndexWidth  = 4;
	localparam int unsigned RgbaWidth   = 32;
	localparam int unsigned OutDataWidth = 40;

	// last texel of a block
	localparam logic [IndexWidth-1:0] LastTexel = 4'd15;

	// reciprocals for the alpha ramp, exact for numerators below 2048
	localparam int unsigned    RecipShift = 15;
	localparam logic [12:0]    Recip7     = 13'd4682;
	localparam logic [12:0]    Recip5     = 13'd6554;

	// alpha source codes of the format register
	typedef enum logic [1:0] {
		FMT_RGB      = 2'd0,
		FMT_EXPLICIT = 2'd1,
		FMT_INTERP   = 2'd2,
		FMT_INTERP_X = 2'd3
	} fmt_t;

	// how the final alpha value is formed in the last stage
	typedef enum logic [1:0] {
		ALPHA_DIRECT = 2'd0,
		ALPHA_DIV7   = 2'd1,
		ALPHA_DIV5   = 2'd2
	} alpha_kind_t;

	// 5-bit channel to 8 bits by bit replication
	function automatic logic [7:0] widen5(input logic [4:0] v);
		widen5 = {v, v[4:2]};
	endfunction

	// 6-bit channel to 8 bits by bit replication
	function automatic logic [7:0] widen6(input logic [5:0] v);
		widen6 = {v, v[5:4]};
	endfunction

endpackage

`default_nettype wire

FILE: src/atc_texture_block_decoder.sv
// atc texture block decoder top level: block register, sequencer and three-stage texel pipeline
`default_nettype none

// Decodes one compressed 4x4 block per input beat into sixteen RGBA8888 output beats in
// raster order, tlast on the sixteenth. The texel sequencer walks the held block one texel
// per cycle unless the output stalls it; the next block is accepted in the cycle its last
// texel enters the pipeline, so blocks stream with no gap. A texel leaving the sequencer
// passes the expand, palette and ramp numerator, and ramp divide stages to its output beat.
// The format register picks the alpha source and must be written only while the block is
// idle.
module atc_texture_block_decoder
	import atc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// format register write
	input  wire logic                    cfg_wr_en,
	input  wire logic [1:0]              cfg_wr_data,
	// input blocks
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [InDataWidth-1:0]  s_axis_tdata,  // color_block[63:0], alpha_block[127:64]
	// output texels
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [OutDataWidth-1:0]      m_axis_tdata,  // pixel_index[3:0], pixel_rgba[35:4], zero pad
	output logic                         m_axis_tlast   // last_pixel
);

	// format register
	logic [1:0] format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_RGB;
		end else if (cfg_wr_en) begin
			format_q <= cfg_wr_data;
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic blk_valid_q;
	logic [IndexWidth-1:0] cnt_q;
	logic emit;
	logic s_beat;

	assign rdy_s3 = !v_s3 || m_axis_tready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign emit   = blk_valid_q && rdy_s1;
	assign s_axis_tready = !blk_valid_q || (rdy_s1 && cnt_q == LastTexel);
	assign s_beat = s_axis_tvalid && s_axis_tready;

	// held block and texel sequencer
	logic [BlockWidth-1:0] cb_q, ab_q;
	logic [1:0]            fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (s_beat) begin
			blk_valid_q <= 1'b1;
			cnt_q       <= '0;
		end else if (emit) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LastTexel) begin
				blk_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			cb_q  <= s_axis_tdata[BlockWidth-1:0];
			ab_q  <= s_axis_tdata[InDataWidth-1:BlockWidth];
			fmt_q <= format_q;
		end
	end

	// stage 1: channel expansion and per-texel index extraction
	logic [7:0]            e0_s1 [3];
	logic [7:0]            e1_s1 [3];
	logic                  mode_s1;
	logic [1:0]            cidx_s1;
	logic [1:0]            fmt_s1;
	logic [3:0]            nib_s1;
	logic [2:0]            aidx_s1;
	logic [7:0]            a0_s1, a1_s1;
	logic [IndexWidth-1:0] pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			e0_s1[0] <= widen5(cb_q[4:0]);
			e0_s1[1] <= widen5(cb_q[9:5]);
			e0_s1[2] <= widen5(cb_q[14:10]);
			e1_s1[0] <= widen5(cb_q[20:16]);
			e1_s1[1] <= widen6(cb_q[26:21]);
			e1_s1[2] <= widen5(cb_q[31:27]);
			mode_s1  <= cb_q[15];
			cidx_s1  <= cb_q[32 + 2*cnt_q +: 2];
			fmt_s1   <= fmt_q;
			nib_s1   <= ab_q[4*cnt_q +: 4];
			aidx_s1  <= ab_q[16 + 3*cnt_q +: 3];
			a0_s1    <= ab_q[7:0];
			a1_s1    <= ab_q[15:8];
			pix_s1   <= cnt_q;
		end
	end

	// stage 2 logic: palette entry per channel
	logic [23:0] rgb_c;

	always_comb begin
		logic [10:0] mix;
		logic [7:0]  q;
		rgb_c = '0;
		for (int ch = 0; ch < 3; ch++) begin
			mix = '0;
			q   = e1_s1[ch] >> 2;
			case (cidx_s1)
				2'd0: rgb_c[8*ch +: 8] = mode_s1 ? 8'd0 : e0_s1[ch];
				2'd1: begin
					if (mode_s1) begin
						rgb_c[8*ch +: 8] = (e0_s1[ch] > q) ? e0_s1[ch] - q : 8'd0;
					end else begin
						mix = 11'(e0_s1[ch]) * 11'd5 + 11'(e1_s1[ch]) * 11'd3;
						rgb_c[8*ch +: 8] = mix[10:3];
					end
				end
				2'd2: begin
					if (mode_s1) begin
						rgb_c[8*ch +: 8] = e0_s1[ch];
					end else begin
						mix = 11'(e0_s1[ch]) * 11'd3 + 11'(e1_s1[ch]) * 11'd5;
						rgb_c[8*ch +: 8] = mix[10:3];
					end
				end
				default: rgb_c[8*ch +: 8] = e1_s1[ch];
			endcase
		end
	end

	// stage 2 logic: alpha source and ramp numerator
	alpha_kind_t akind_c;
	logic [7:0]  aval_c;
	logic [10:0] anum_c;

	always_comb begin
		logic [2:0] k;
		k       = aidx_s1 - 3'd1;
		akind_c = ALPHA_DIRECT;
		aval_c  = 8'hff;
		anum_c  = '0;
		case (fmt_s1)
			FMT_RGB:      aval_c = 8'hff;
			FMT_EXPLICIT: aval_c = {nib_s1, nib_s1};
			default: begin
				if (aidx_s1 == 3'd0) begin
					aval_c = a0_s1;
				end else if (aidx_s1 == 3'd1) begin
					aval_c = a1_s1;
				end else if (a0_s1 > a1_s1) begin
					akind_c = ALPHA_DIV7;
					anum_c  = 11'(3'd7 - k) * 11'(a0_s1) + 11'(k) * 11'(a1_s1);
				end else if (aidx_s1 == 3'd6) begin
					aval_c = 8'd0;
				end else if (aidx_s1 == 3'd7) begin
					aval_c = 8'hff;
				end else begin
					akind_c = ALPHA_DIV5;
					anum_c  = 11'(3'd5 - k) * 11'(a0_s1) + 11'(k) * 11'(a1_s1);
				end
			end
		endcase
	end

	// stage 2 registers
	logic [23:0]           rgb_s2;
	alpha_kind_t           akind_s2;
	logic [7:0]            aval_s2;
	logic [10:0]           anum_s2;
	logic [IndexWidth-1:0] pix_s2;
	logic                  adv_s2;

	assign adv_s2 = v_s1 && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rgb_s2   <= rgb_c;
			akind_s2 <= akind_c;
			aval_s2  <= aval_c;
			anum_s2  <= anum_c;
			pix_s2   <= pix_s1;
		end
	end

	// stage 3 logic: ramp division by reciprocal multiply
	logic [23:0] prod_c;
	logic [7:0]  alpha_c;

	always_comb begin
		prod_c = 24'(anum_s2) * 24'((akind_s2 == ALPHA_DIV7) ? Recip7 : Recip5);
		unique case (akind_s2)
			ALPHA_DIV7, ALPHA_DIV5: alpha_c = prod_c[RecipShift +: 8];
			default:                alpha_c = aval_s2;
		endcase
	end

	// stage 3: output register
	logic adv_s3;

	assign adv_s3 = v_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			m_axis_tdata <= {4'd0, alpha_c, rgb_s2, pix_s2};
			m_axis_tlast <= (pix_s2 == LastTexel);
		end
	end

	assign m_axis_tvalid = v_s3;

	// texels in adjacent stages are consecutive in raster order
	a_seq_s12: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 |-> pix_s1 == pix_s2 + 4'd1)
		else $error("stage 1 and 2 texels out of order");

	a_seq_s23: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && v_s3 |-> pix_s2 == m_axis_tdata[3:0] + 4'd1)
		else $error("stage 2 and 3 texels out of order");

	// a new block is taken only while the held one is on its last texel
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid_q && s_axis_tready |-> cnt_q == LastTexel && emit)
		else $error("block accepted while texels remain");

	// tlast marks the sixteenth texel only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tlast == (m_axis_tdata[3:0] == LastTexel))
		else $error("tlast does not match texel index");

endmodule

`default_nettype wire
